### hdl/tt2_pkg.sv
// Types, codes and reset values shared by the two-slot transposition table.
`default_nettype none
package tt2_pkg;

	localparam int unsigned TT2_ENTRIES = 1024;

	localparam logic [14:0] SCORE_LIMIT_RST = 15'd32767;
	localparam logic [6:0]  NO_MOVE_RST     = 7'd64;

	localparam logic REG_SCORE_LIMIT = 1'b0;
	localparam logic REG_NO_MOVE     = 1'b1;

	localparam logic [1:0] CMD_PROBE = 2'd0;
	localparam logic [1:0] CMD_STORE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] HIT_MISS      = 2'd0;
	localparam logic [1:0] HIT_PRIMARY   = 2'd1;
	localparam logic [1:0] HIT_SECONDARY = 2'd2;

	localparam logic [2:0] STS_NEW_PRI   = 3'd0;
	localparam logic [2:0] STS_NEW_SEC   = 3'd1;
	localparam logic [2:0] STS_SAME      = 3'd2;
	localparam logic [2:0] STS_LEVEL_UP  = 3'd3;
	localparam logic [2:0] STS_OVER_PRI  = 3'd4;
	localparam logic [2:0] STS_OVER_SEC  = 3'd5;
	localparam logic [2:0] STS_COLLISION = 3'd6;

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EVAL
	} tt2_state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [9:0]         hash_index;
		logic [63:0]        own_stones;
		logic [63:0]        opp_stones;
		logic [6:0]         search_depth;
		logic [6:0]         best_move;
		logic signed [15:0] alpha_bound;
		logic signed [15:0] beta_bound;
		logic signed [15:0] found_score;
	} tt2_req_t;

	typedef struct packed {
		logic [1:0]         hit_slot;
		logic signed [15:0] lower_out;
		logic signed [15:0] upper_out;
		logic [6:0]         depth_out;
		logic [6:0]         first_move_out;
		logic [6:0]         second_move_out;
		logic [2:0]         store_status;
	} tt2_rsp_t;

	typedef struct packed {
		logic [63:0]        own;
		logic [63:0]        opp;
		logic [6:0]         depth;
		logic [6:0]         best;
		logic [6:0]         second;
		logic signed [15:0] lower;
		logic signed [15:0] upper;
	} tt2_entry_t;

	typedef struct packed {
		logic       valid;
		tt2_entry_t entry;
	} tt2_word_t;

	typedef struct packed {
		logic       wr_en;
		logic       wr_to_q;
		tt2_entry_t wr_entry;
	} tt2_wb_t;

endpackage
`default_nettype wire

### hdl/tt2_mem.sv
// Entry memory with two registered read ports and one write port.
`default_nettype none
module tt2_mem
	import tt2_pkg::*;
#(
	parameter int unsigned DEPTH = TT2_ENTRIES,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr_a,
	input  wire logic [AW-1:0] rd_addr_b,
	output tt2_word_t          rd_data_a,
	output tt2_word_t          rd_data_b,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire tt2_word_t     wr_data
);

	tt2_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

### hdl/tt2_decide.sv
// Probe lookup and store replacement decision for one pair of slots.
`default_nettype none
module tt2_decide
	import tt2_pkg::*;
(
	input  wire tt2_req_t     item,
	input  wire tt2_word_t    slot_p,
	input  wire tt2_word_t    slot_q,
	input  wire logic [14:0]  score_limit,
	input  wire logic [6:0]   no_move_code,
	output tt2_rsp_t          rsp,
	output tt2_wb_t           wb
);

	logic signed [15:0] lim_pos;
	logic signed [15:0] lim_neg;
	logic signed [15:0] s_v;
	logic signed [15:0] a_v;
	logic signed [15:0] b_v;
	logic signed [15:0] el_v;
	logic signed [15:0] eu_v;
	logic               good;
	logic               match_p;
	logic               match_q;
	tt2_entry_t         hit_e;
	tt2_entry_t         new_e;
	tt2_entry_t         ref_e;
	tt2_entry_t         lvl_e;
	tt2_entry_t         upd_e;
	logic [2:0]         upd_sts;

	assign lim_pos = $signed({1'b0, score_limit});
	assign lim_neg = -lim_pos;
	assign s_v     = item.found_score;
	assign a_v     = item.alpha_bound;
	assign b_v     = item.beta_bound;
	assign good    = (s_v > a_v) || (s_v == lim_neg);

	assign match_p = slot_p.valid && (slot_p.entry.own == item.own_stones)
		&& (slot_p.entry.opp == item.opp_stones);
	assign match_q = slot_q.valid && (slot_q.entry.own == item.own_stones)
		&& (slot_q.entry.opp == item.opp_stones);

	assign hit_e = match_p ? slot_p.entry : slot_q.entry;
	assign el_v  = hit_e.lower;
	assign eu_v  = hit_e.upper;

	always_comb begin
		new_e        = '0;
		new_e.own    = item.own_stones;
		new_e.opp    = item.opp_stones;
		new_e.depth  = item.search_depth;
		new_e.best   = good ? item.best_move : no_move_code;
		new_e.second = no_move_code;
		new_e.upper  = (s_v < b_v) ? s_v : lim_pos;
		new_e.lower  = (s_v > a_v) ? s_v : lim_neg;
	end

	always_comb begin
		ref_e = hit_e;
		if ((s_v < b_v) && (s_v < eu_v)) begin
			ref_e.upper = s_v;
		end
		if ((s_v > a_v) && (s_v > el_v)) begin
			ref_e.lower = s_v;
		end
		if (good && (hit_e.best != item.best_move)) begin
			ref_e.second = hit_e.best;
			ref_e.best   = item.best_move;
		end
	end

	always_comb begin
		lvl_e       = hit_e;
		lvl_e.upper = new_e.upper;
		lvl_e.lower = new_e.lower;
		lvl_e.depth = item.search_depth;
		if (good) begin
			lvl_e.second = hit_e.best;
			lvl_e.best   = item.best_move;
		end else begin
			lvl_e.best = no_move_code;
		end
	end

	always_comb begin
		if (item.search_depth == hit_e.depth) begin
			upd_sts = STS_SAME;
			upd_e   = ($signed(ref_e.lower) > $signed(ref_e.upper)) ? new_e : ref_e;
		end else begin
			upd_sts = STS_LEVEL_UP;
			upd_e   = lvl_e;
		end
	end

	always_comb begin
		rsp = '0;
		wb  = '0;
		if (item.cmd == CMD_PROBE) begin
			if (match_p || match_q) begin
				rsp.hit_slot        = match_p ? HIT_PRIMARY : HIT_SECONDARY;
				rsp.lower_out       = hit_e.lower;
				rsp.upper_out       = hit_e.upper;
				rsp.depth_out       = hit_e.depth;
				rsp.first_move_out  = hit_e.best;
				rsp.second_move_out = hit_e.second;
			end
		end else if (item.cmd == CMD_STORE) begin
			wb.wr_en = 1'b1;
			priority if (!slot_p.valid) begin
				rsp.store_status = STS_NEW_PRI;
				wb.wr_entry      = new_e;
			end else if (match_p) begin
				rsp.store_status = upd_sts;
				wb.wr_entry      = upd_e;
			end else if (!slot_q.valid) begin
				rsp.store_status = STS_NEW_SEC;
				wb.wr_to_q       = 1'b1;
				wb.wr_entry      = new_e;
			end else if (match_q) begin
				rsp.store_status = upd_sts;
				wb.wr_to_q       = 1'b1;
				wb.wr_entry      = upd_e;
			end else if (item.search_depth > slot_p.entry.depth) begin
				rsp.store_status = STS_OVER_PRI;
				wb.wr_entry      = new_e;
			end else if (item.search_depth > slot_q.entry.depth) begin
				rsp.store_status = STS_OVER_SEC;
				wb.wr_to_q       = 1'b1;
				wb.wr_entry      = new_e;
			end else begin
				rsp.store_status = STS_COLLISION;
				wb.wr_en         = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/two_slot_transposition_table_unit.sv
// Two-slot transposition table: control, configuration registers and result register.
// Accepted requests go to S_EVAL, which registers the result unless a held result stalls.
// Requests are taken one at a time; the next stalls until the entry write-back is done.
// Reset clears control state and loads the configuration registers with their reset values,
// then sweeps the table marking every entry empty while requests stall. A clear request
// starts the same sweep once its result has been registered.
`default_nettype none
module two_slot_transposition_table_unit
	import tt2_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TT2_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire tt2_req_t    req_data,
	output logic             res_valid,
	input  wire logic        res_stall,
	output tt2_rsp_t         res_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned IDX_W      = $clog2(TABLE_ENTRIES);
	localparam logic [31:0] IDX_MASK   = 32'(TABLE_ENTRIES - 1);
	localparam logic [31:0] IDX_LIMIT  = 32'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	tt2_state_t       state_q;
	tt2_state_t       state_nxt;
	logic [IDX_W-1:0] sweep_cnt_q;
	logic             sweep_we;
	logic             sweep_last;
	logic             eval_fire;
	logic             accept;

	logic [14:0]      limit_q;
	logic [6:0]       no_move_q;
	logic             cfg_wr;

	logic [31:0]      p_raw;
	logic [31:0]      p_full;
	logic [31:0]      q_raw;
	logic [31:0]      q_full;

	tt2_req_t         item_s1;
	logic [IDX_W-1:0] p_s1;
	logic [IDX_W-1:0] q_s1;

	tt2_word_t        slot_p;
	tt2_word_t        slot_q;
	tt2_rsp_t         dec_rsp;
	tt2_wb_t          dec_wb;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	tt2_word_t        mem_wdata;

	tt2_rsp_t         res_q;
	logic             res_valid_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= SCORE_LIMIT_RST;
			no_move_q <= NO_MOVE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SCORE_LIMIT) begin
				limit_q <= pwdata[14:0];
			end else begin
				no_move_q <= pwdata[6:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_NO_MOVE) ? {25'd0, no_move_q} : {17'd0, limit_q};

	assign p_raw  = {22'd0, req_data.hash_index} & IDX_MASK;
	assign p_full = (p_raw >= IDX_LIMIT) ? 32'd0 : p_raw;
	assign q_raw  = p_full ^ 32'd1;
	assign q_full = (q_raw >= IDX_LIMIT) ? p_full : q_raw;

	always_comb begin
		unique case (state_q)
			S_SWEEP: state_nxt = sweep_last ? S_IDLE : S_SWEEP;
			S_IDLE:  state_nxt = req_valid ? S_EVAL : S_IDLE;
			S_EVAL: begin
				if (eval_fire) begin
					state_nxt = (item_s1.cmd == CMD_CLEAR) ? S_SWEEP : S_IDLE;
				end else begin
					state_nxt = S_EVAL;
				end
			end
			default: state_nxt = S_SWEEP;
		endcase
	end

	always_comb begin
		req_stall = (state_q != S_IDLE);
		sweep_we  = (state_q == S_SWEEP);
		eval_fire = (state_q == S_EVAL) && (!res_valid_q || !res_stall);
	end

	assign accept     = req_valid && !req_stall;
	assign sweep_last = (sweep_cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_cnt_q <= '0;
		end else begin
			state_q     <= state_nxt;
			sweep_cnt_q <= sweep_we ? sweep_cnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_data;
			p_s1    <= p_full[IDX_W-1:0];
			q_s1    <= q_full[IDX_W-1:0];
		end
	end

	assign mem_we    = sweep_we || (eval_fire && dec_wb.wr_en);
	assign mem_waddr = sweep_we ? sweep_cnt_q : (dec_wb.wr_to_q ? q_s1 : p_s1);
	assign mem_wdata = sweep_we ? tt2_word_t'('0) : {1'b1, dec_wb.wr_entry};

	tt2_mem #(
		.DEPTH(TABLE_ENTRIES)
	) u_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (p_full[IDX_W-1:0]),
		.rd_addr_b (q_full[IDX_W-1:0]),
		.rd_data_a (slot_p),
		.rd_data_b (slot_q),
		.wr_en     (mem_we),
		.wr_addr   (mem_waddr),
		.wr_data   (mem_wdata)
	);

	tt2_decide u_decide (
		.item         (item_s1),
		.slot_p       (slot_p),
		.slot_q       (slot_q),
		.score_limit  (limit_q),
		.no_move_code (no_move_q),
		.rsp          (dec_rsp),
		.wb           (dec_wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (eval_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_fire) begin
			res_q <= dec_rsp;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(eval_fire && (item_s1.cmd == CMD_CLEAR)) |=> (state_q == S_SWEEP))
		else $error("clear request did not start the sweep");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("entry memory written while idle");

	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_EVAL))
		else $error("result appeared without an evaluation");

endmodule
`default_nettype wire
